// File: rtl/core/sccbm_pkg.sv
package sccbm_pkg;

  localparam int unsigned MaxReadLen = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] DevAddrShortRst = 8'h42;
  localparam logic [7:0] DevAddrWideRst  = 8'hB8;
  localparam logic [7:0] WrRetryRst      = 8'd20;
  localparam logic [7:0] RdRetryRst      = 8'd30;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_WR8   = 2'd1,
    REQ_RD    = 2'd2,
    REQ_WR16  = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    CFG_DEV_SHORT = 2'd0,
    CFG_DEV_WIDE  = 2'd1,
    CFG_WR_RETRY  = 2'd2,
    CFG_RD_RETRY  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    K_START = 2'd0,
    K_SEND  = 2'd1,
    K_RECV  = 2'd2,
    K_STOP  = 2'd3
  } op_kind_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  reg_addr;
    logic [15:0] wr_data;
    logic [4:0]  rd_length;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_listening;
    logic       busy_res;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       rd_last;
    logic       done_res;
    logic       failed;
  } res_t;

  typedef struct packed {
    logic [7:0] dev_addr_short;
    logic [7:0] dev_addr_wide;
    logic [7:0] write_retry_limit;
    logic [7:0] read_retry_limit;
  } cfg_t;

  function automatic op_kind_e op_kind(input logic [1:0] kind, input logic [2:0] op);
    op_kind_e k;
    k = K_STOP;
    case (kind)
      REQ_WR8: begin
        if (op == 3'd0) k = K_START;
        else if (op <= 3'd3) k = K_SEND;
      end
      REQ_RD: begin
        if (op == 3'd0 || op == 3'd4) k = K_START;
        else if (op == 3'd1 || op == 3'd2 || op == 3'd5) k = K_SEND;
        else if (op == 3'd6) k = K_RECV;
      end
      REQ_WR16: begin
        if (op == 3'd0) k = K_START;
        else if (op <= 3'd4) k = K_SEND;
      end
      default: k = K_STOP;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] last_op(input logic [1:0] kind);
    logic [2:0] r;
    case (kind)
      REQ_WR8:  r = 3'd4;
      REQ_RD:   r = 3'd7;
      REQ_WR16: r = 3'd5;
      default:  r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/sccbm_front.sv
module sccbm_front
  import sccbm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_item_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output req_t q_item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  req_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [PtrW:0]     cnt_q;
  req_t              cls;
  logic              push;

  always_comb begin
    cls = in_item_i;
    if (in_item_i.rd_length > 5'(MaxReadLen)) begin
      cls.rd_length = 5'(MaxReadLen);
    end
  end

  assign in_stall_o = (cnt_q == (PtrW+1)'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (q_pop_i) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end

endmodule

// File: rtl/core/sccbm_back.sv
module sccbm_back
  import sccbm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_valid_i,
  output logic q_pop_o,
  input  req_t q_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_item_o
);

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  sub_q, sub_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  sh_q, sh_d;
  logic [4:0]  bc_q, bc_d;
  logic [7:0]  att_q, att_d;
  logic        ab_q, ab_d;
  logic [1:0]  ty_q, ty_d;
  logic [7:0]  reg_q, reg_d;
  logic [15:0] dat_q, dat_d;
  logic [4:0]  len_q, len_d;
  logic        ov_q;
  res_t        res_q, res;
  logic        adv;

  logic [2:0]  op;
  op_kind_e    kind;
  logic [3:0]  nx_phase;
  logic [7:0]  tx_byte;
  logic        chk;
  logic        last_byte;
  logic [7:0]  lim;
  logic [7:0]  att_inc;
  logic [7:0]  sh_new;

  assign adv     = q_valid_i && (!ov_q || !out_stall_i);
  assign q_pop_o = adv;

  always_comb begin
    phase_d = phase_q; sub_d = sub_q; bit_d = bit_q; sh_d = sh_q;
    bc_d = bc_q; att_d = att_q; ab_d = ab_q; ty_d = ty_q;
    reg_d = reg_q; dat_d = dat_q; len_d = len_q;
    res = '0;
    res.scl_level = 1'b1;
    res.sda_level = 1'b1;
    op = '0; kind = K_STOP; nx_phase = '0; tx_byte = '0; chk = 1'b0;
    last_byte = 1'b0; lim = '0; att_inc = '0; sh_new = '0;

    if (phase_q == '0 && q_item_i.req_type != REQ_NONE) begin
      ty_d = q_item_i.req_type; reg_d = q_item_i.reg_addr;
      dat_d = q_item_i.wr_data; len_d = q_item_i.rd_length;
      att_d = '0; phase_d = 4'd1; sub_d = '0; bit_d = '0;
      sh_d = '0; bc_d = '0; ab_d = 1'b0;
    end

    if (phase_d != '0) begin
      op   = 3'(phase_d - 4'd1);
      kind = ab_d ? K_STOP : op_kind(ty_d, op);
      nx_phase = (op_kind(ty_d, phase_d[2:0]) == K_RECV && len_d == '0) ?
                 phase_d + 4'd2 : phase_d + 4'd1;
      if (op == 3'd2) tx_byte = reg_d;
      else if (ty_d == REQ_WR16) begin
        if (op == 3'd1) tx_byte = cfg_i.dev_addr_wide;
        else if (op == 3'd3) tx_byte = dat_d[15:8];
        else tx_byte = dat_d[7:0];
      end else if (ty_d == REQ_WR8 && op == 3'd3) tx_byte = dat_d[7:0];
      else if (op == 3'd5) tx_byte = cfg_i.dev_addr_short + 8'd1;
      else tx_byte = cfg_i.dev_addr_short;
      chk = (ty_d == REQ_WR16) || op == 3'd1 || op == 3'd5;
      last_byte = ({1'b0, bc_d} + 6'd1) >= {1'b0, len_d};
      lim = (ty_d == REQ_RD) ? cfg_i.read_retry_limit : cfg_i.write_retry_limit;
      if (lim == '0) lim = 8'd1;
      att_inc = att_d + 8'd1;
      sh_new = {sh_d[6:0], q_item_i.sda_in};
      res.busy_res = 1'b1;

      case (kind)
        K_START: begin
          res.scl_level = (sub_d < 2'd2);
          res.sda_level = (sub_d == 2'd0);
          if (sub_d >= 2'd2) begin
            phase_d = nx_phase; sub_d = '0; bit_d = '0;
          end else sub_d = sub_d + 2'd1;
        end
        K_SEND: begin
          res.scl_level = sub_d[0];
          if (bit_d < 4'd8) begin
            res.sda_level = tx_byte[3'(4'd7 - bit_d)];
            if (sub_d[0]) begin
              bit_d = bit_d + 4'd1; sub_d = '0;
            end else sub_d = 2'd1;
          end else begin
            res.sda_listening = 1'b1;
            if (sub_d[0]) begin
              if (q_item_i.sda_in && chk) begin
                ab_d = 1'b1; sub_d = '0;
              end else begin
                phase_d = nx_phase; sub_d = '0; bit_d = '0;
              end
            end else sub_d = 2'd1;
          end
        end
        K_RECV: begin
          res.scl_level = sub_d[0];
          if (bit_d < 4'd8) begin
            res.sda_listening = 1'b1;
            if (sub_d[0]) begin
              sh_d = sh_new;
              if (bit_d == 4'd7) begin
                res.rd_valid = 1'b1;
                res.rd_data  = sh_new;
                res.rd_last  = last_byte;
              end
              bit_d = bit_d + 4'd1; sub_d = '0;
            end else sub_d = 2'd1;
          end else begin
            res.sda_level = last_byte;
            if (sub_d[0]) begin
              bc_d = bc_d + 5'd1; sub_d = '0; bit_d = '0; sh_d = '0;
              if ((bc_d) >= len_d) begin
                phase_d = nx_phase; sub_d = '0; bit_d = '0;
              end
            end else sub_d = 2'd1;
          end
        end
        default: begin
          res.scl_level = (sub_d >= 2'd1);
          res.sda_level = (sub_d >= 2'd2);
          if (sub_d < 2'd2) sub_d = sub_d + 2'd1;
          else if (ab_d) begin
            att_d = att_inc;
            if (att_inc >= lim) begin
              res.done_res = 1'b1; res.failed = 1'b1; phase_d = '0;
            end else begin
              phase_d = 4'd1; sub_d = '0; bit_d = '0; sh_d = '0;
              bc_d = '0; ab_d = 1'b0;
            end
          end else if (op >= last_op(ty_d)) begin
            res.done_res = 1'b1; phase_d = '0;
          end else begin
            phase_d = nx_phase; sub_d = '0; bit_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0; sub_q <= '0; bit_q <= '0; sh_q <= '0; bc_q <= '0;
      att_q <= '0; ab_q <= 1'b0; ty_q <= '0; reg_q <= '0; dat_q <= '0;
      len_q <= '0; ov_q <= 1'b0;
    end else begin
      if (adv) begin
        phase_q <= phase_d; sub_q <= sub_d; bit_q <= bit_d; sh_q <= sh_d;
        bc_q <= bc_d; att_q <= att_d; ab_q <= ab_d; ty_q <= ty_d;
        reg_q <= reg_d; dat_q <= dat_d; len_q <= len_d;
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res;
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = res_q;

endmodule

// File: rtl/core/sccb_master_with_retries_core.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_item_i (req_t)
// out       output     out_valid_o/out_stall_i out_item_o (res_t)
// cfg       input      cfg_we_i               cfg_idx_i, cfg_wdata_i
// One item is taken per cycle while in_stall_o is low; each item yields one result
// item, registered first in the two-entry queue and then in the sequencer's
// output register. The sequencer steps once per item.
// Reset clears the queue, the sequencer and the registers to their defaults.
// A stalled output holds the sequencer; the queue then fills and stalls the input.
module sccb_master_with_retries_core
  import sccbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       out_item_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic q_valid, q_pop;
  req_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr_short    <= DevAddrShortRst;
      cfg_q.dev_addr_wide     <= DevAddrWideRst;
      cfg_q.write_retry_limit <= WrRetryRst;
      cfg_q.read_retry_limit  <= RdRetryRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEV_SHORT: cfg_q.dev_addr_short    <= cfg_wdata_i;
        CFG_DEV_WIDE:  cfg_q.dev_addr_wide     <= cfg_wdata_i;
        CFG_WR_RETRY:  cfg_q.write_retry_limit <= cfg_wdata_i;
        CFG_RD_RETRY:  cfg_q.read_retry_limit  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sccbm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  sccbm_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_stall_i, .out_item_o
  );

`ifndef NO_ASSERTIONS
  a_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.failed |-> out_item_o.done_res)
    else $error("failure reported without done");
  a_rd_listen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.rd_valid |-> out_item_o.sda_listening && out_item_o.busy_res)
    else $error("read byte outside a listening phase");
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.busy_res |-> out_item_o.scl_level && out_item_o.sda_level)
    else $error("lines driven while idle");
`endif

endmodule
